FILE: hdl/g2u_pkg.sv
// Package for the GB2312 to UCS-2 stream decoder: payload structs, stage
// control struct and the code-table constants of the GB2312 row layout.
// No dependencies.
package g2u_pkg;

	localparam int MAP_DEPTH_DEFAULT = 8192;

	localparam logic [7:0]  ROW_FIRST_LO  = 8'hA1;
	localparam logic [7:0]  ROW_FIRST_HI  = 8'hA9;
	localparam logic [7:0]  ROW_SECOND_LO = 8'hB0;
	localparam logic [7:0]  ROW_SECOND_HI = 8'hF7;
	localparam logic [7:0]  COL_LO        = 8'hA1;
	localparam logic [7:0]  COL_HI        = 8'hFE;
	localparam logic [6:0]  ROW_LEN       = 7'd94;
	localparam logic [6:0]  SECOND_BASE   = 7'd9;
	localparam logic [15:0] REPLACEMENT   = 16'hFDFF;
	localparam logic [7:0]  HIGH_BYTE     = 8'h80;
	localparam logic [13:0] ENTRIES_RESET = 14'd8192;

	localparam logic MODE_MAP_WRITE = 1'b0;
	localparam logic MODE_CONVERT   = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [12:0] map_index;
		logic [15:0] map_word;
		logic [7:0]  gb_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last;
	} out_item_t;

	// Control carried from the accept stage to the result stage.
	typedef struct packed {
		logic        two;      // replacement followed by the terminator
		logic        use_mem;  // result comes from the mapping memory read
		logic [15:0] code;     // result when the memory is not used
	} s1_ctrl_t;

endpackage

FILE: hdl/gb2312_to_ucs2_stream_decoder_core.sv
// Top level of the GB2312 to byte-swapped UCS-2 stream decoder.
// Holds the mapping memory, the lead-byte state and the output register.
// Depends on g2u_pkg.
//
// Usage. Input items arrive on in_valid/in_stall/in_data. An item with
// mode 0 writes one word of the mapping memory and gives no result. An item
// with mode 1 carries one text byte. A byte below 0x80 yields byte<<8, a zero
// byte yields the terminator 0, and a byte of 0x80 or above is held as a lead
// byte; the following byte is its trail, and the pair is decoded through the
// mapping memory (row*94+col), or yields 0xFDFF when out of the GB2312 rows,
// the trail range, the configured entry count or the memory depth. A zero
// byte right after a lead gives two transfers: 0xFDFF with last low, then 0
// with last high. Results leave on out_valid/out_stall/out_data.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the number
// of mapping entries in use; it is always ready. The user must write it only
// while the block is idle; the block itself does not enforce this.
// An input transfer is registered in the result stage and then in the output
// register before it shows on out_valid.
// One item is taken every cycle while in_stall is low: the mapping memory has
// one write port and one read port with a registered read, and a write always
// lands before any later read. A zero after a lead yields two output transfers.
// When the receiver stalls, the output register holds its transfer and the
// result stage holds the next one; in_stall then rises until room frees.
// Reset clears the lead state, the pipeline valid bits and sets the entry
// count to 8192; memory contents are undefined until written.
module gb2312_to_ucs2_stream_decoder_core #(
	parameter int MAP_DEPTH = g2u_pkg::MAP_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  g2u_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output g2u_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data
);

	localparam int AW = $clog2(MAP_DEPTH);

	// Configuration register.
	logic [13:0] entries_q;

	// Lead-byte state.
	logic       lead_pending_q;
	logic [7:0] lead_byte_q;

	// Mapping memory and its registered read.
	logic [15:0] map_mem [MAP_DEPTH];
	logic [15:0] rd_s1;

	// Result stage.
	logic              valid_s1;
	g2u_pkg::s1_ctrl_t ctrl_s1;
	logic              second_q;

	// Output register.
	logic               out_valid_q;
	g2u_pkg::out_item_t out_q;

	logic              accept;
	logic              out_ok;
	logic              s1_done;
	logic              emit;
	g2u_pkg::s1_ctrl_t ctrl_next;
	logic              lookup_ok;
	logic [6:0]        row;
	logic              row_ok;
	logic              col_ok;
	logic [12:0]       idx;
	logic [7:0]        b;
	g2u_pkg::out_item_t s1_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= g2u_pkg::ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	// Handshake between the stages. The result stage releases its item once
	// the output register can take the final result of that item.
	assign out_ok   = !out_valid_q || !out_stall;
	assign s1_done  = valid_s1 && out_ok && !(ctrl_s1.two && !second_q);
	assign in_stall = valid_s1 && !s1_done;
	assign accept   = in_valid && !in_stall;

	// Pair decode: row and column of the GB2312 code, compacted index.
	assign b = in_data.gb_byte;

	always_comb begin
		row    = '0;
		row_ok = 1'b0;
		if (lead_byte_q inside {[g2u_pkg::ROW_FIRST_LO : g2u_pkg::ROW_FIRST_HI]}) begin
			row    = 7'(lead_byte_q - g2u_pkg::ROW_FIRST_LO);
			row_ok = 1'b1;
		end else if (lead_byte_q inside {[g2u_pkg::ROW_SECOND_LO : g2u_pkg::ROW_SECOND_HI]}) begin
			row    = 7'(lead_byte_q - g2u_pkg::ROW_SECOND_LO) + g2u_pkg::SECOND_BASE;
			row_ok = 1'b1;
		end
	end

	assign col_ok    = b inside {[g2u_pkg::COL_LO : g2u_pkg::COL_HI]};
	assign idx       = 13'(row * g2u_pkg::ROW_LEN) + 13'(b - g2u_pkg::COL_LO);
	assign lookup_ok = row_ok && col_ok && ({1'b0, idx} < entries_q)
		&& (32'(idx) < MAP_DEPTH);

	// What an accepted conversion item produces.
	always_comb begin
		emit      = 1'b0;
		ctrl_next = '{two: 1'b0, use_mem: 1'b0, code: g2u_pkg::REPLACEMENT};
		if (in_data.mode == g2u_pkg::MODE_CONVERT) begin
			if (lead_pending_q) begin
				emit = 1'b1;
				if (b == 8'h00) begin
					ctrl_next.two = 1'b1;
				end else begin
					ctrl_next.use_mem = lookup_ok;
				end
			end else if (b == 8'h00) begin
				emit           = 1'b1;
				ctrl_next.code = 16'h0000;
			end else if (b < g2u_pkg::HIGH_BYTE) begin
				emit           = 1'b1;
				ctrl_next.code = {b, 8'h00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_byte_q    <= '0;
		end else if (accept && in_data.mode == g2u_pkg::MODE_CONVERT) begin
			if (lead_pending_q) begin
				lead_pending_q <= 1'b0;
			end else if (b >= g2u_pkg::HIGH_BYTE) begin
				lead_pending_q <= 1'b1;
				lead_byte_q    <= b;
			end
		end
	end

	// Mapping memory: write on a mode 0 transfer, read on a conversion
	// transfer. The read data stays put while the result stage waits.
	always_ff @(posedge clk) begin
		if (accept && in_data.mode == g2u_pkg::MODE_MAP_WRITE
			&& 32'(in_data.map_index) < MAP_DEPTH) begin
			map_mem[AW'(in_data.map_index)] <= in_data.map_word;
		end
		if (accept && in_data.mode == g2u_pkg::MODE_CONVERT) begin
			rd_s1 <= map_mem[AW'(idx)];
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= emit;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				second_q <= 1'b0;
			end else if (valid_s1 && out_ok && ctrl_s1.two) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_next;
		end
	end

	always_comb begin
		if (ctrl_s1.two && !second_q) begin
			s1_item = '{code_unit: g2u_pkg::REPLACEMENT, last: 1'b0};
		end else if (ctrl_s1.two) begin
			s1_item = '{code_unit: 16'h0000, last: 1'b1};
		end else begin
			s1_item = '{code_unit: ctrl_s1.use_mem ? rd_s1 : ctrl_s1.code, last: 1'b1};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ok) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ok && valid_s1) begin
			out_q <= s1_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The second half of a two-result item only exists inside such an item.
	a_second_in_two: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (valid_s1 && ctrl_s1.two))
		else $error("second result flag set outside a two-result item");

	// A lead byte taken with nothing pending is held for the next byte.
	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == g2u_pkg::MODE_CONVERT && !lead_pending_q
			&& in_data.gb_byte >= g2u_pkg::HIGH_BYTE)
		|=> (lead_pending_q && lead_byte_q == $past(in_data.gb_byte)))
		else $error("lead byte not held");

	// Only the replacement of a zero-after-lead item goes out without last.
	a_nonlast_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> (out_q.code_unit == g2u_pkg::REPLACEMENT))
		else $error("non-final result is not the replacement value");

	// A non-final result is always followed by the terminator of its item.
	a_term_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last && !out_stall)
		|=> (out_valid_q && out_q.last && out_q.code_unit == 16'h0000))
		else $error("terminator did not follow the replacement value");

	// A memory-write item never creates a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == g2u_pkg::MODE_MAP_WRITE) |=> !valid_s1)
		else $error("memory write produced a result");

endmodule

FILE: dv/tb_gb2312_to_ucs2_stream_decoder_core.sv
// Self-checking testbench for the GB2312 to UCS-2 stream decoder: directed text, entry-limit
// sweeps and random byte streams with random idling on both channels.
// Depends on g2u_pkg and gb2312_to_ucs2_stream_decoder_core.
module tb_gb2312_to_ucs2_stream_decoder_core;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	g2u_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	g2u_pkg::out_item_t out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [13:0]        cfg_data;

	int idle_pct;
	int stall_pct;
	int items_sent;
	int error_count;

	// Shadow of the decoder: mapping table, entry limit and the held lead byte.
	g2u_pkg::out_item_t expected_units[$];
	logic [15:0] map_shadow [0:g2u_pkg::MAP_DEPTH_DEFAULT-1];
	bit          map_written [0:g2u_pkg::MAP_DEPTH_DEFAULT-1];
	int          entry_limit;
	bit          lead_held;
	logic [7:0]  lead_value;

	g2u_pkg::out_item_t held_unit;
	bit                 held;

	gb2312_to_ucs2_stream_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("gb2312_to_ucs2_stream_decoder_core test failed");
		$finish;
	end

	// Table index of a lead/trail pair, or -1 when the pair lies outside the GB2312 rows or the trail range.
	function automatic int pair_index(input logic [7:0] lead, input logic [7:0] trail);
		int row;
		if (trail < g2u_pkg::COL_LO || trail > g2u_pkg::COL_HI)
			return -1;
		if (lead >= g2u_pkg::ROW_FIRST_LO && lead <= g2u_pkg::ROW_FIRST_HI)
			row = int'(lead) - int'(g2u_pkg::ROW_FIRST_LO);
		else if (lead >= g2u_pkg::ROW_SECOND_LO && lead <= g2u_pkg::ROW_SECOND_HI)
			row = int'(lead) - int'(g2u_pkg::ROW_SECOND_LO) + int'(g2u_pkg::SECOND_BASE);
		else
			return -1;
		return row * int'(g2u_pkg::ROW_LEN) + int'(trail) - int'(g2u_pkg::COL_LO);
	endfunction

	function automatic logic [15:0] pair_code(input logic [7:0] lead, input logic [7:0] trail);
		int idx;
		idx = pair_index(lead, trail);
		if (idx < 0 || idx >= entry_limit || idx >= g2u_pkg::MAP_DEPTH_DEFAULT)
			return g2u_pkg::REPLACEMENT;
		return map_shadow[idx];
	endfunction

	task automatic expect_unit(input logic [15:0] code, input logic last);
		g2u_pkg::out_item_t unit;
		unit.code_unit = code;
		unit.last = last;
		expected_units.push_back(unit);
	endtask

	// Updates the shadow state for one accepted transfer and queues the code units it yields.
	task automatic decode_transfer(input g2u_pkg::in_item_t it);
		if (it.mode == g2u_pkg::MODE_MAP_WRITE) begin
			if (it.map_index < g2u_pkg::MAP_DEPTH_DEFAULT) begin
				map_shadow[it.map_index] = it.map_word;
				map_written[it.map_index] = 1'b1;
			end
		end else if (lead_held) begin
			lead_held = 1'b0;
			if (it.gb_byte == 8'h00) begin
				expect_unit(g2u_pkg::REPLACEMENT, 1'b0);
				expect_unit(16'h0000, 1'b1);
			end else begin
				expect_unit(pair_code(lead_value, it.gb_byte), 1'b1);
			end
		end else if (it.gb_byte == 8'h00) begin
			expect_unit(16'h0000, 1'b1);
		end else if (it.gb_byte < g2u_pkg::HIGH_BYTE) begin
			expect_unit({it.gb_byte, 8'h00}, 1'b1);
		end else begin
			lead_held = 1'b1;
			lead_value = it.gb_byte;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		error_count++;
		$display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
	endtask

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Result checker: every transfer is matched against the oldest queued code unit, and a stalled transfer must hold.
	always @(posedge clk) begin
		g2u_pkg::out_item_t want;
		if (arst_n) begin
			if (held && (!out_valid || out_data != held_unit))
				report_mismatch("stalled transfer", out_data.code_unit, held_unit.code_unit);
			if (out_valid && !out_stall) begin
				if (expected_units.size() == 0) begin
					report_mismatch("unexpected transfer", out_data.code_unit, 16'h0000);
				end else begin
					want = expected_units.pop_front();
					if (out_data.code_unit !== want.code_unit)
						report_mismatch("code_unit", out_data.code_unit, want.code_unit);
					if (out_data.last !== want.last)
						report_mismatch("last", {15'd0, out_data.last}, {15'd0, want.last});
				end
			end
			held = out_valid && out_stall;
			held_unit = out_data;
		end
	end

	// Called just after a falling edge; returns just after the falling edge that follows
	// the accepting rising edge.
	task automatic send_item(input g2u_pkg::in_item_t it);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		in_data = it;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		decode_transfer(it);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_map_write(input int idx, input logic [15:0] word);
		g2u_pkg::in_item_t it;
		it.mode = g2u_pkg::MODE_MAP_WRITE;
		it.map_index = idx[12:0];
		it.map_word = word;
		it.gb_byte = 8'($urandom);
		send_item(it);
	endtask

	// A trail that would look up a table entry never loaded gets that entry loaded first;
	// the load goes in between the lead and the trail.
	task automatic send_text_byte(input logic [7:0] b);
		g2u_pkg::in_item_t it;
		int idx;
		if (lead_held) begin
			idx = pair_index(lead_value, b);
			if (idx >= 0 && !map_written[idx])
				send_map_write(idx, 16'($urandom));
		end
		it.mode = g2u_pkg::MODE_CONVERT;
		it.map_index = 13'($urandom);
		it.map_word = 16'($urandom);
		it.gb_byte = b;
		send_item(it);
	endtask

	task automatic wait_all_results();
		while (expected_units.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_entry_limit(input int limit);
		wait_all_results();
		// A lead byte or a table load may still be in flight without any result.
		repeat (4) @(negedge clk);
		cfg_data = limit[13:0];
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		entry_limit = limit;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_pair(input logic [7:0] lead, input logic [7:0] trail);
		send_text_byte(lead);
		send_text_byte(trail);
	endtask

	task automatic test_directed_decode();
		send_map_write(0, 16'hFFFF);
		send_map_write(7613, 16'h8000);
		send_text_byte(8'h01);
		send_text_byte(8'h7F);
		send_text_byte(8'h00);
		send_pair(8'hA1, 8'hA1);    // first table entry
		send_pair(8'hF7, 8'hFE);    // last table entry
		send_pair(8'h80, 8'h41);    // low trail after a lead is still a trail
		send_pair(8'hAA, 8'hA1);    // row in the gap between the two row blocks
		send_pair(8'hA1, 8'hA0);    // trail below the column range
		send_pair(8'hA1, 8'hFF);    // trail above the column range
		send_pair(8'hA1, 8'h00);    // zero after a lead gives two code units
		send_pair(8'hFF, 8'hFF);
		send_pair(8'hB0, 8'hA1);    // first row of the second block
		// A table load between a lead and its trail keeps the lead.
		send_text_byte(8'hA9);
		send_map_write(845, 16'h1234);
		send_text_byte(8'hFE);
	endtask

	task automatic test_entry_limit();
		int limits[5];
		limits = '{0, 1, 7613, 7614, 8192};
		foreach (limits[i]) begin
			write_entry_limit(limits[i]);
			send_pair(8'hA1, 8'hA1);
			send_pair(8'hA1, 8'hA2);
			send_pair(8'hF7, 8'hFE);
		end
	endtask

	task automatic send_random_unit();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			if ($urandom_range(1) == 0)
				send_pair(8'($urandom_range(g2u_pkg::ROW_FIRST_HI, g2u_pkg::ROW_FIRST_LO)),
					8'($urandom_range(g2u_pkg::COL_HI, g2u_pkg::COL_LO)));
			else
				send_pair(8'($urandom_range(g2u_pkg::ROW_SECOND_HI, g2u_pkg::ROW_SECOND_LO)),
					8'($urandom_range(g2u_pkg::COL_HI, g2u_pkg::COL_LO)));
		end else if (pick < 60) begin
			send_text_byte(8'($urandom_range(8'h7F, 8'h01)));
		end else if (pick < 68) begin
			send_map_write($urandom_range(g2u_pkg::MAP_DEPTH_DEFAULT - 1), 16'($urandom));
		end else if (pick < 75) begin
			send_text_byte(8'h00);
		end else if (pick < 82) begin
			send_pair(8'($urandom_range(8'hFF, 8'h80)), 8'h00);
		end else if (pick < 92) begin
			send_text_byte(8'($urandom));
		end else begin
			send_pair(8'($urandom_range(8'hFF, 8'h80)), 8'($urandom_range(255, 1)));
		end
	endtask

	task automatic test_random_stream(input int count, input int limit, input int idle,
			input int stall, input bit pause_for_results);
		int stop_at;
		write_entry_limit(limit);
		idle_pct = idle;
		stall_pct = stall;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			send_random_unit();
			if (pause_for_results && $urandom_range(19) == 0)
				wait_all_results();
		end
		idle_pct = 30;
		stall_pct = 30;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 30;
		stall_pct = 30;
		items_sent = 0;
		error_count = 0;
		entry_limit = int'(g2u_pkg::ENTRIES_RESET);
		lead_held = 1'b0;
		lead_value = 8'h00;
		held = 1'b0;
		held_unit = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_decode();
		test_entry_limit();
		test_random_stream(130, 8192, 30, 30, 1'b0);
		test_random_stream(130, $urandom_range(8192), 0, 0, 1'b0);
		test_random_stream(120, $urandom_range(7614, 600), 30, 30, 1'b1);
		test_random_stream(120, 8192, 30, 30, 1'b0);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("gb2312_to_ucs2_stream_decoder_core test passed");
		else
			$display("gb2312_to_ucs2_stream_decoder_core test failed");
		$finish;
	end

endmodule
